>>> hdl/pcpu_pkg.sv
// ----------------------------------------------------------------------------
// pcpu_pkg
// Types, codes and helper functions shared by the paged 8-bit processor core.
// ----------------------------------------------------------------------------
package pcpu_pkg;

    localparam int STORE_DEPTH = 65536;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // item modes
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_EXEC  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // major opcodes
    localparam logic [3:0] OP_SYS   = 4'h0;
    localparam logic [3:0] OP_SUB   = 4'h1;
    localparam logic [3:0] OP_LOAD  = 4'h2;
    localparam logic [3:0] OP_STORE = 4'h3;
    localparam logic [3:0] OP_SKIP  = 4'h4;
    localparam logic [3:0] OP_JALR  = 4'h5;
    localparam logic [3:0] OP_NAND  = 4'h6;
    localparam logic [3:0] OP_ADD   = 4'h7;
    localparam logic [3:0] OP_MISC  = 4'h8;
    localparam logic [1:0] SLI_PREFIX = 2'b11;

    // sub-opcodes
    localparam logic [1:0] SYS_NOP    = 2'd0;
    localparam logic [1:0] SYS_HALT   = 2'd1;
    localparam logic [1:0] SYS_JMPFAR = 2'd2;
    localparam logic [1:0] SYS_PAGE   = 2'd3;
    localparam logic [1:0] SKIP_Z     = 2'd0;
    localparam logic [1:0] SKIP_NZ    = 2'd1;
    localparam logic [1:0] SKIP_NEG   = 2'd2;
    localparam logic [1:0] SKIP_POS   = 2'd3;
    localparam logic [1:0] MISC_INC   = 2'd0;
    localparam logic [1:0] MISC_DEC   = 2'd1;
    localparam logic [1:0] MISC_OUT   = 2'd2;
    localparam logic [1:0] MISC_IN    = 2'd3;

    localparam logic [1:0] REG_C     = 2'd2;
    localparam logic [7:0] SIGN_MASK = 8'h80;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ADDR_W-1:0] address;
        logic [7:0]        write_byte;
        logic [7:0]        in_char_high;
        logic [7:0]        in_char_low;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       char_valid;
        logic [7:0] char_out;
        logic       halted_flag;
        logic [7:0] pc_now;
        logic [7:0] code_page_now;
        logic [7:0] data_page_now;
        logic [7:0] reg_a_now;
        logic [7:0] reg_b_now;
        logic [7:0] reg_c_now;
        logic [7:0] reg_d_now;
    } out_item_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic load_wb;
        logic push;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] in_mode;
        logic       halted;
        logic       op_is_load;
        logic       out_free;
    } dp_status_t;

    // digit or letter value of a character (0-9, then A-Z or a-z from 10); other codes pass through unchanged
    function automatic logic [7:0] char_value(input logic [7:0] c);
        logic [7:0] v;
        begin
            v = c;
            if (c >= "0" && c <= "9")
            begin
                v = c - 8'h30;
            end
            else if (c >= "A" && c <= "Z")
            begin
                v = c - 8'h41 + 8'd10;
            end
            else if (c >= "a" && c <= "z")
            begin
                v = c - 8'h61 + 8'd10;
            end
            return v;
        end
    endfunction

endpackage

>>> hdl/pcpu_if.sv
// ----------------------------------------------------------------------------
// pcpu_if
// Valid/ready channels for the input items and the result items.
// ----------------------------------------------------------------------------
interface pcpu_in_if;
    import pcpu_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pcpu_out_if;
    import pcpu_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/paged_8bit_cpu_core.sv
// ----------------------------------------------------------------------------
// paged_8bit_cpu_core
// 8-bit processor with four registers and paged 64K byte store.
// ----------------------------------------------------------------------------
// Usage:
//   item   : input channel, one transfer per command (write byte, execute one
//            instruction, read byte). ready is high only while the core is
//            idle, so one command is in progress at a time.
//   result : output channel, exactly one transfer per command, carrying the
//            read byte, any OUT character and the architectural state after
//            the command.
//   Steps: write, read, halted step or unused mode go from acceptance to
//   the result state; an instruction is fetched at acceptance, then
//   executed, and LOAD adds a write-back state. The single store port sets
//   these: instruction fetch, then one data access. A new command is taken
//   only once the previous result has moved into the result register.
//   Reset clears PC, pages, registers and halt; store contents are unknown
//   until written. The result register holds a finished result while the
//   receiver stalls; the next item may be taken meanwhile, but its result
//   waits until the held one has been transferred.
// ----------------------------------------------------------------------------
module paged_8bit_cpu_core
(
    input  logic       clk,
    input  logic       rst_n,
    pcpu_in_if.sink    item,
    pcpu_out_if.source result
);
    import pcpu_pkg::*;

    dp_cmd_t           cmd;
    dp_status_t        st;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_wdata;
    logic [7:0]        mem_rdata;

    pcpu_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .st       (st),
        .cmd      (cmd)
    );

    pcpu_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (item.data),
        .cmd       (cmd),
        .st        (st),
        .mem_we    (mem_we),
        .mem_re    (mem_re),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (result.data)
    );

    pcpu_ram u_ram
    (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );
endmodule

>>> hdl/pcpu_ram.sv
// ----------------------------------------------------------------------------
// pcpu_ram
// Single-port byte store with registered read data.
// ----------------------------------------------------------------------------
module pcpu_ram
(
    input  logic                       clk,
    input  logic                       we,
    input  logic                       re,
    input  logic [pcpu_pkg::ADDR_W-1:0] addr,
    input  logic [7:0]                 wdata,
    output logic [7:0]                 rdata
);
    import pcpu_pkg::*;

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> hdl/pcpu_ctrl.sv
// ----------------------------------------------------------------------------
// pcpu_ctrl
// Sequencer: accept, execute, load write-back and result hand-off.
// ----------------------------------------------------------------------------
module pcpu_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pcpu_pkg::dp_status_t st,
    output pcpu_pkg::dp_cmd_t    cmd
);
    import pcpu_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (st.in_mode == MODE_EXEC && !st.halted)
                    begin
                        state_next = S_EXEC;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = st.op_is_load ? S_LOAD : S_RESULT;
            end
            S_LOAD:
            begin
                cmd.load_wb = 1'b1;
                state_next  = S_RESULT;
            end
            S_RESULT:
            begin
                if (st.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

>>> hdl/pcpu_dp.sv
// ----------------------------------------------------------------------------
// pcpu_dp
// Architectural state, instruction execution, store access and result register.
// ----------------------------------------------------------------------------
module pcpu_dp
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  pcpu_pkg::in_item_t          in_data,
    input  pcpu_pkg::dp_cmd_t           cmd,
    output pcpu_pkg::dp_status_t        st,
    output logic                        mem_we,
    output logic                        mem_re,
    output logic [pcpu_pkg::ADDR_W-1:0] mem_addr,
    output logic [7:0]                  mem_wdata,
    input  logic [7:0]                  mem_rdata,
    output logic                        out_valid,
    input  logic                        out_ready,
    output pcpu_pkg::out_item_t         out_data
);
    import pcpu_pkg::*;

    logic [7:0]      pc_reg, pc_next;
    logic [7:0]      cp_reg, cp_next;
    logic [7:0]      dp_reg, dp_next;
    logic            halt_reg, halt_next;
    logic [3:0][7:0] gpr_reg, gpr_next;
    logic [1:0]      mode_reg, mode_next;
    logic [7:0]      chh_reg, chh_next;
    logic [7:0]      chl_reg, chl_next;
    logic            cv_reg, cv_next;
    logic [7:0]      co_reg, co_next;
    logic [1:0]      ir_rd_reg, ir_rd_next;
    logic            out_valid_reg, out_valid_next;
    out_item_t       out_data_reg, out_data_next;

    logic [3:0] op4;
    logic [1:0] rd;
    logic [1:0] rs;
    logic [3:0] imm;
    logic [7:0] rd_val;
    logic [7:0] rs_val;
    logic [7:0] pc_inc;
    logic [7:0] hv;
    logic [7:0] lv;
    logic       skip;

    assign op4    = mem_rdata[7:4];
    assign rd     = mem_rdata[3:2];
    assign rs     = mem_rdata[1:0];
    assign imm    = {mem_rdata[5:4], mem_rdata[1:0]};
    assign rd_val = gpr_reg[rd];
    assign rs_val = gpr_reg[rs];
    assign pc_inc = pc_reg + 8'd1;
    assign hv     = char_value(chh_reg);
    assign lv     = char_value(chl_reg);

    always_comb
    begin
        case (rs)
            SKIP_Z:   skip = (rd_val == 8'd0);
            SKIP_NZ:  skip = (rd_val != 8'd0);
            SKIP_NEG: skip = ((rd_val & SIGN_MASK) != 8'd0);
            SKIP_POS: skip = ((rd_val & SIGN_MASK) == 8'd0);
            default:  skip = 1'b0;
        endcase
    end

    assign st.in_mode    = in_data.mode;
    assign st.halted     = halt_reg;
    assign st.op_is_load = (op4 == OP_LOAD);
    assign st.out_free   = !out_valid_reg || out_ready;

    // store port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = {dp_reg, rs_val};
        mem_wdata = rd_val;
        if (cmd.accept)
        begin
            mem_wdata = in_data.write_byte;
            if (in_data.mode == MODE_EXEC)
            begin
                mem_addr = {cp_reg, pc_reg};
                mem_re   = !halt_reg;
            end
            else
            begin
                mem_addr = in_data.address;
                mem_re   = (in_data.mode == MODE_READ);
                mem_we   = (in_data.mode == MODE_WRITE);
            end
        end
        else if (cmd.exec)
        begin
            mem_re = (op4 == OP_LOAD);
            mem_we = (op4 == OP_STORE);
        end
    end

    // state update
    always_comb
    begin
        pc_next    = pc_reg;
        cp_next    = cp_reg;
        dp_next    = dp_reg;
        halt_next  = halt_reg;
        gpr_next   = gpr_reg;
        mode_next  = mode_reg;
        chh_next   = chh_reg;
        chl_next   = chl_reg;
        cv_next    = cv_reg;
        co_next    = co_reg;
        ir_rd_next = ir_rd_reg;
        if (cmd.accept)
        begin
            mode_next = in_data.mode;
            chh_next  = in_data.in_char_high;
            chl_next  = in_data.in_char_low;
            cv_next   = 1'b0;
            co_next   = 8'd0;
        end
        if (cmd.exec)
        begin
            pc_next    = pc_inc;
            ir_rd_next = rd;
            if (op4[3:2] == SLI_PREFIX)
            begin
                gpr_next[rd] = {rd_val[3:0], imm};
            end
            else
            begin
                case (op4)
                    OP_SYS:
                    begin
                        case (rs)
                            SYS_NOP:
                            begin
                            end
                            SYS_HALT:
                            begin
                                halt_next = 1'b1;
                            end
                            SYS_JMPFAR:
                            begin
                                cp_next      = gpr_reg[REG_C];
                                pc_next      = rs_val;
                                gpr_next[rd] = pc_inc;
                            end
                            SYS_PAGE:
                            begin
                                dp_next = rd_val;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    OP_SUB:
                    begin
                        gpr_next[rd] = rd_val - rs_val;
                    end
                    OP_SKIP:
                    begin
                        if (skip)
                        begin
                            pc_next = pc_reg + 8'd2;
                        end
                    end
                    OP_JALR:
                    begin
                        pc_next      = rs_val;
                        gpr_next[rd] = pc_inc;
                    end
                    OP_NAND:
                    begin
                        gpr_next[rd] = ~(rd_val & rs_val);
                    end
                    OP_ADD:
                    begin
                        gpr_next[rd] = rd_val + rs_val;
                    end
                    OP_MISC:
                    begin
                        case (rs)
                            MISC_INC: gpr_next[rd] = rd_val + 8'd1;
                            MISC_DEC: gpr_next[rd] = rd_val - 8'd1;
                            MISC_OUT:
                            begin
                                cv_next = 1'b1;
                                co_next = rd_val;
                            end
                            MISC_IN:  gpr_next[rd] = {hv[3:0], 4'd0} | lv;
                            default:
                            begin
                            end
                        endcase
                    end
                    default:
                    begin
                        // load and store move data through the store port;
                        // reserved opcodes only advance the PC
                    end
                endcase
            end
        end
        if (cmd.load_wb)
        begin
            gpr_next[ir_rd_reg] = mem_rdata;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (cmd.push)
        begin
            out_valid_next              = 1'b1;
            out_data_next.read_byte     = (mode_reg == MODE_READ) ? mem_rdata : 8'd0;
            out_data_next.char_valid    = cv_reg;
            out_data_next.char_out      = co_reg;
            out_data_next.halted_flag   = halt_reg;
            out_data_next.pc_now        = pc_reg;
            out_data_next.code_page_now = cp_reg;
            out_data_next.data_page_now = dp_reg;
            out_data_next.reg_a_now     = gpr_reg[0];
            out_data_next.reg_b_now     = gpr_reg[1];
            out_data_next.reg_c_now     = gpr_reg[2];
            out_data_next.reg_d_now     = gpr_reg[3];
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= 8'd0;
            cp_reg        <= 8'd0;
            dp_reg        <= 8'd0;
            halt_reg      <= 1'b0;
            gpr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            cp_reg        <= cp_next;
            dp_reg        <= dp_next;
            halt_reg      <= halt_next;
            gpr_reg       <= gpr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        chh_reg      <= chh_next;
        chl_reg      <= chl_next;
        cv_reg       <= cv_next;
        co_reg       <= co_next;
        ir_rd_reg    <= ir_rd_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
endmodule

>>> hdl/pcpu_checker.sv
// ----------------------------------------------------------------------------
// pcpu_checker
// Port-level checks on the processor core, bound to the top level.
// ----------------------------------------------------------------------------
module pcpu_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input pcpu_pkg::out_item_t out_data
);
    import pcpu_pkg::*;

    logic       in_xfer;
    logic       out_xfer;
    logic [1:0] pend_reg, pend_next;
    logic       halt_seen_reg, halt_seen_next;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_comb
    begin
        pend_next = pend_reg + {1'b0, in_xfer} - {1'b0, out_xfer};
        halt_seen_next = halt_seen_reg || (out_xfer && out_data.halted_flag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 2'd0;
            halt_seen_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            halt_seen_reg <= halt_seen_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("item taken while previous one in progress");

    a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result without a pending item");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("too many items outstanding");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && halt_seen_reg |-> out_data.halted_flag)
        else $error("halt flag cleared after halt");
endmodule

bind paged_8bit_cpu_core pcpu_checker u_pcpu_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);
